FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Constants and types shared by the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sida_pkg;

  // Width of the value port, and the number of its low bits that are used.
  localparam int INPUT_WIDTH = 64;
  localparam int VALUE_WIDTH = 64;

  // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1).
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_WIDTH  = NUM_DIGITS * 4;
  localparam int CNT_WIDTH  = $clog2(VALUE_WIDTH);

  localparam int CHAR_WIDTH = 6;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 6'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Commands from the sequencer to the digit shifter.
  typedef struct packed {
    logic load;       // take a new magnitude, clear the digits
    logic shift_bin;  // one double dabble step
    logic shift_bcd;  // move the next digit to the top
  } ctrl_t;

endpackage

FILE: src/signed_int_to_decimal_ascii_unit.sv
// A word accepted while idle shows its minus sign (negative words only), then its
// digits, the final one with is_last_o. Busy stays high through the one-bit-per-cycle
// double dabble loop, a sign slot and one slot per decimal digit; a new word is taken
// only once busy has fallen. Results cannot be stalled. Reset is asynchronous, active
// low, to idle.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts one signed integer word to its decimal ASCII text, one character
// per strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [sida_pkg::INPUT_WIDTH-1:0]  value_i,
  output logic                              strobe_o,
  output logic [sida_pkg::CHAR_WIDTH-1:0]   character_o,
  output logic                              is_last_o
);
  import sida_pkg::*;

  // Commands from the sequencer into the digit shifter.
  ctrl_t      ctrl;
  // The digit currently at the top of the BCD register.
  logic [3:0] digit;

  // The shifter forms the magnitude when a word is loaded and then takes
  // one binary bit per cycle into its BCD register. Afterwards it presents
  // the digits, most significant first, one per cycle.
  sida_dabble u_dabble (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .value_i (value_i[VALUE_WIDTH-1:0]),
    .digit_o (digit)
  );

  // The sequencer counts the dabble steps, then spends one slot on the
  // minus sign (strobed only for negative words) and one slot per digit.
  // Leading zero digits use their slot silently. The units digit slot is
  // always strobed and carries the last flag, so zero gives a single '0'.
  sida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .sign_i      (value_i[VALUE_WIDTH-1]),
    .digit_i     (digit),
    .ctrl_o      (ctrl),
    .busy        (busy),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .is_last_o   (is_last_o)
  );

endmodule

FILE: src/sida_dabble.sv
// ----------------------------------------------------------------------------
// sida_dabble
// Bit-serial double dabble: binary magnitude shifts into a BCD register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sida_dabble (
  input  logic                              clk_i,
  input  sida_pkg::ctrl_t                   ctrl_i,
  input  logic [sida_pkg::VALUE_WIDTH-1:0]  value_i,
  output logic [3:0]                        digit_o
);
  import sida_pkg::*;

  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_WIDTH-1:0]   bcd_q, bcd_d;
  logic [BCD_WIDTH-1:0]   bcd_adj;
  logic [VALUE_WIDTH-1:0] magnitude;

  // Two's complement magnitude; the most negative value maps to 2^(W-1).
  assign magnitude = value_i[VALUE_WIDTH-1] ? ((~value_i) + VALUE_WIDTH'(1)) : value_i;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    if (ctrl_i.load) begin
      mag_d = magnitude;
      bcd_d = '0;
    end else if (ctrl_i.shift_bin) begin
      mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_d = {bcd_adj[BCD_WIDTH-2:0], mag_q[VALUE_WIDTH-1]};
    end else if (ctrl_i.shift_bcd) begin
      bcd_d = {bcd_q[BCD_WIDTH-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign digit_o = bcd_q[BCD_WIDTH-1 -: 4];

endmodule

FILE: src/sida_ctrl.sv
// ----------------------------------------------------------------------------
// sida_ctrl
// Sequencer: conversion steps, sign slot, digit slots and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sida_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              sign_i,
  input  logic [3:0]                        digit_i,
  output sida_pkg::ctrl_t                   ctrl_o,
  output logic                              busy,
  output logic                              strobe_o,
  output logic [sida_pkg::CHAR_WIDTH-1:0]   character_o,
  output logic                              is_last_o
);
  import sida_pkg::*;

  state_e                state_q, state_d;
  logic [CNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic                  sign_q, sign_d;
  logic                  seen_q, seen_d;
  logic                  strobe_q, strobe_d;
  logic                  last_q, last_d;
  logic [CHAR_WIDTH-1:0] char_q, char_d;
  logic                  final_digit;
  logic                  nonzero;

  assign final_digit = (cnt_q == CNT_WIDTH'(NUM_DIGITS - 1));
  assign nonzero     = (digit_i != 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      sign_q   <= 1'b0;
      seen_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sign_q   <= sign_d;
      seen_q   <= seen_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sign_d   = sign_q;
    seen_d   = seen_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    ctrl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          sign_d      = sign_i;
          cnt_d       = '0;
          state_d     = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        ctrl_o.shift_bin = 1'b1;
        if (cnt_q == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
          cnt_d   = '0;
          state_d = ST_SIGN;
        end else begin
          cnt_d = cnt_q + CNT_WIDTH'(1);
        end
      end
      ST_SIGN: begin
        strobe_d = sign_q;
        char_d   = CHAR_MINUS;
        last_d   = 1'b0;
        seen_d   = 1'b0;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        // Leading zeros are dropped, except the units digit of zero itself.
        ctrl_o.shift_bcd = 1'b1;
        strobe_d = seen_q | nonzero | final_digit;
        char_d   = CHAR_ZERO + {2'b00, digit_i};
        last_d   = final_digit;
        seen_d   = seen_q | nonzero;
        cnt_d    = cnt_q + CNT_WIDTH'(1);
        if (final_digit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign is_last_o   = last_q;

endmodule

FILE: src/sida_checker.sv
// ----------------------------------------------------------------------------
// sida_checker
// Port-level checks for the decimal text unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sida_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              strobe_o,
  input logic [sida_pkg::CHAR_WIDTH-1:0]   character_o,
  input logic                              is_last_o
);
  import sida_pkg::*;

  logic accept;
  logic legal_char;

  assign accept     = start && !busy;
  assign legal_char = (character_o == CHAR_MINUS) ||
                      ((character_o >= CHAR_ZERO) && (character_o <= CHAR_NINE));

  // An accepted word keeps the unit busy on the next cycle.
  `ASSERT_CLK(a_accept_busy, clk_i, rst_ni, accept |=> busy, "accept did not raise busy")
  // Only a minus sign or a decimal digit is ever strobed.
  `ASSERT_CLK(a_legal_char, clk_i, rst_ni, strobe_o |-> legal_char, "illegal character")
  // The minus sign is always followed by digits.
  `ASSERT_NEVER(a_minus_last, clk_i, rst_ni,
    strobe_o && is_last_o && (character_o == CHAR_MINUS), "minus flagged last")
  // The end of a conversion shows exactly the final character.
  `ASSERT_CLK(a_done_last, clk_i, rst_ni, $fell(busy) |-> (strobe_o && is_last_o),
    "busy fell without a final character")
  // A final character is never directly followed by another character.
  `ASSERT_CLK(a_gap_after_last, clk_i, rst_ni, (strobe_o && is_last_o) |=> !strobe_o,
    "character right after the final one")

endmodule

bind signed_int_to_decimal_ascii_unit sida_checker u_sida_checker (.*);
